// ===== src/streaming_kth_largest_top_macros.svh =====
// assertion macros for the streaming k-th largest block
`ifndef STREAMING_KTH_LARGEST_TOP_MACROS_SVH
`define STREAMING_KTH_LARGEST_TOP_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define KTHL_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define KTHL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/kthl_pkg.sv =====
// ----------------------------------------------------------------------------
// kthl_pkg
// shared types and constants of the streaming k-th largest block
// ----------------------------------------------------------------------------
`default_nettype none

package kthl_pkg;

  localparam int VALUE_W      = 32;
  localparam int RANK_W       = 5;
  localparam int MAX_RANK_DEF = 16;

  localparam logic [RANK_W-1:0] RANK_RESET = 5'd1;

  typedef logic signed [VALUE_W-1:0] value_t;

  // one result item
  typedef struct packed {
    value_t kth_value;
    logic   short_set;
  } out_item_t;

  // control from the top level to one cell
  typedef struct packed {
    logic below_used;  // cell index below used (the fill count, or k-1 once full)
    logic upto_used;   // cell index at or below used (the fill count, or k-1 once full)
    logic write_en;    // an accepted item is inserted this cycle
  } cell_ctl_t;

  // status from one cell
  typedef struct packed {
    logic gt;     // new value strictly greater than the held one
    logic after;  // cell lies at or past the insertion point
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== src/kthl_ifs.sv =====
// ----------------------------------------------------------------------------
// kthl_ifs
// valid/ready channels for input and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface kthl_in_if;
  logic            valid;
  logic            ready;
  kthl_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface kthl_out_if;
  logic            valid;
  logic            ready;
  kthl_pkg::value_t kth_value;
  logic            short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

`default_nettype wire

// ===== src/streaming_kth_largest_top.sv =====
// ----------------------------------------------------------------------------
// streaming_kth_largest_top
// k-th largest value of a stream of signed sets
// ----------------------------------------------------------------------------
// The block takes one signed 32-bit value per cycle and keeps the k largest
// values of the current set in a row of MAX_RANK cells, sorted from largest
// to smallest. Every cell compares its value with the new one in the same
// cycle and either holds, takes the new value or takes its upper neighbor,
// so an item is taken every cycle unless the input is stalled. On
// the item marked last the smallest held value (the k-th largest) is
// registered as a result, with short_set raised when the set had fewer
// than k values; the count then clears for the next set. A result
// register and one skid entry decouple the two channels: input stalls
// only when both hold results not yet taken. rank_k is written through
// cfg_we/cfg_wdata by the user only while idle, not enforced by the block;
// 0 acts as 1 and values above MAX_RANK act as MAX_RANK. There is no
// clearing pass after reset: held cells past the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "streaming_kth_largest_top_macros.svh"

module streaming_kth_largest_top #(
  parameter int MaxRank = kthl_pkg::MAX_RANK_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [kthl_pkg::RANK_W-1:0]   cfg_wdata,
  kthl_in_if.sink                      in_item,
  kthl_out_if.source                   out_item
);

  // count width, wide enough to hold MaxRank itself
  localparam int CW = $clog2(MaxRank + 1);
  localparam logic [CW-1:0] MAX_K = CW'(MaxRank);

  // rank register
  logic [kthl_pkg::RANK_W-1:0] rank_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r <= kthl_pkg::RANK_RESET;
    end else if (cfg_we) begin
      rank_k_r <= cfg_wdata;
    end
  end

  // effective rank, clamped into 1..MaxRank
  logic [31:0]   rank_ext;
  logic [CW-1:0] k_eff;

  assign rank_ext = 32'(rank_k_r);

  always_comb begin
    if (rank_ext == 32'd0) begin
      k_eff = CW'(1);
    end else if (rank_ext > 32'(MaxRank)) begin
      k_eff = MAX_K;
    end else begin
      k_eff = rank_ext[CW-1:0];
    end
  end

  // handshake
  logic can_take;
  logic in_acc;

  assign in_item.ready = can_take;
  assign in_acc        = in_item.valid && can_take;

  // fill count, cut back to k if the rank was lowered mid-set
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_eff;
  logic [CW-1:0] count_new;
  logic [CW-1:0] used;
  logic          not_full;

  assign count_eff = (count_r > k_eff) ? k_eff : count_r;
  assign not_full  = count_eff < k_eff;
  // while filling every held cell is in play, once full the tail is dropped
  assign used      = not_full ? count_eff : k_eff - CW'(1);
  assign count_new = not_full ? count_eff + CW'(1) : k_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= in_item.last ? '0 : count_new;
    end
  end

  // cell row
  kthl_pkg::value_t     cell_val [MaxRank];
  kthl_pkg::value_t     cell_nxt [MaxRank];
  kthl_pkg::cell_stat_t cell_stat [MaxRank];
  kthl_pkg::cell_ctl_t  cell_ctl [MaxRank];
  logic [MaxRank-1:0]   gt_vec;
  logic [MaxRank-1:0]   tail_sel;  // cell holding the k-th entry
  logic [MaxRank-1:0]   out_sel;   // cell holding the smallest entry after update
  logic                 do_insert;

  // a full list takes the value only if it beats the k-th entry
  assign do_insert = not_full || |(tail_sel & gt_vec);

  for (genvar i = 0; i < MaxRank; i++) begin : g_cell
    kthl_pkg::value_t prev_value;
    logic             prev_after;

    assign gt_vec[i]   = cell_stat[i].gt;
    assign tail_sel[i] = CW'(i) == (k_eff - CW'(1));
    assign out_sel[i]  = CW'(i) == (count_new - CW'(1));

    assign cell_ctl[i] = '{below_used: CW'(i) <  used,
                           upto_used:  CW'(i) <= used,
                           write_en:   in_acc && do_insert};

    if (i == 0) begin : g_head
      // nothing above the head cell
      assign prev_value = '0;
      assign prev_after = 1'b0;
    end else begin : g_body
      assign prev_value = cell_val[i-1];
      assign prev_after = cell_stat[i-1].after;
    end

    kthl_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_value  (in_item.value),
      .prev_value (prev_value),
      .prev_after (prev_after),
      .value_o    (cell_val[i]),
      .next_o     (cell_nxt[i]),
      .stat_o     (cell_stat[i])
    );
  end

  // smallest held entry after this item goes in
  kthl_pkg::value_t    tail_value;
  kthl_pkg::out_item_t res_item;

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < MaxRank; i++) begin
      if (out_sel[i]) begin
        tail_value = tail_value | cell_nxt[i];
      end
    end
  end

  assign res_item = '{kth_value: tail_value, short_set: count_new < k_eff};

  kthl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && in_item.last),
    .push_item (res_item),
    .can_take  (can_take),
    .out_item  (out_item)
  );

  // checks
  `KTHL_ASSERT_CLK(a_count_clears, (in_acc && in_item.last) |=> (count_r == '0),
    "count not cleared after last item")
  `KTHL_ASSERT_CLK(a_stall_has_result, !in_item.ready |-> out_item.valid,
    "input stalled with no result pending")
  `KTHL_ASSERT_CLK(a_last_gives_result,
    (in_acc && in_item.last && !out_item.valid) |=> out_item.valid,
    "last item gave no result")
  `KTHL_ASSERT_ALWAYS(a_count_in_range, !rst_n || (count_r <= MAX_K),
    "fill count beyond row length")

endmodule

`default_nettype wire

// ===== src/kthl_cell.sv =====
// ----------------------------------------------------------------------------
// kthl_cell
// one slot of the sorted chain, takes the new value or its upper neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module kthl_cell (
  input  wire                    clk,
  input  kthl_pkg::cell_ctl_t    ctl,
  input  kthl_pkg::value_t       new_value,
  input  kthl_pkg::value_t       prev_value,
  input  wire                    prev_after,
  output kthl_pkg::value_t       value_o,
  output kthl_pkg::value_t       next_o,
  output kthl_pkg::cell_stat_t   stat_o
);

  kthl_pkg::value_t value_r;
  kthl_pkg::value_t value_nxt;
  logic             gt;
  logic             after;
  logic             wr;

  assign gt    = new_value > value_r;
  assign after = !ctl.below_used || gt;
  assign wr    = ctl.write_en && ctl.upto_used && after;

  // first cell past the insertion point takes the new value, the rest shift down
  assign value_nxt = wr ? (prev_after ? prev_value : new_value) : value_r;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign next_o  = value_nxt;
  assign stat_o  = '{gt: gt, after: after};

endmodule

`default_nettype wire

// ===== src/kthl_out_buf.sv =====
// ----------------------------------------------------------------------------
// kthl_out_buf
// result register with one skid entry
// ----------------------------------------------------------------------------
`default_nettype none

module kthl_out_buf (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  kthl_pkg::out_item_t  push_item,
  output logic                 can_take,
  kthl_out_if.source           out_item
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  kthl_pkg::out_item_t main_r, main_nxt;
  kthl_pkg::out_item_t skid_r, skid_nxt;
  logic                pop;

  assign pop = main_valid_r && out_item.ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_item;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_item;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign can_take           = !skid_valid_r;
  assign out_item.valid     = main_valid_r;
  assign out_item.kth_value = main_r.kth_value;
  assign out_item.short_set = main_r.short_set;

endmodule

`default_nettype wire
